@@ design/acfl_pkg.sv @@
// shared types and constants for the associative cache hit tracker
package acfl_pkg;

    localparam int BLOCK_W  = 7;
    localparam int COUNT_W  = 32;
    localparam int WAYS_W   = 7;
    localparam int CFG_W    = 6;
    localparam int CFG_A_W  = 1;
    localparam int IN_TD_W  = 8;
    localparam int OUT_TD_W = 72;

    localparam logic [CFG_A_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_WAYS   = 1'd1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CFG_W-1:0]   WAYS_RESET = 6'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear;
        logic lru_upd;
        logic fifo_upd;
    } t_cell_ctrl;

endpackage

@@ design/assoc_cache_fifo_lru_hit_tracker.sv @@
// top level of the fully associative cache hit tracker
//
// Input stream: one beat per referenced block; tdata holds block_number,
// tuser holds start_run, which clears the entries' valid bits, insert pointer
// and counts before the reference is looked up.
// Output stream: one beat per reference with the hit flag and the
// running hit and reference counts, both saturating.
// Configuration: write port, index 0 policy (0 fifo, 1 lru), index 1 ways
// in use; write only while idle.
// For each item the accept edge latches the tag; then, once the output
// register is free, the update cycle runs the compare across the row of
// entry cells, the lowest-match chain through the row and the update of
// every cell at once, and registers the result. A new beat is taken only
// after the current one has updated. The output register holds its beat
// while the receiver stalls; one more input beat is taken meanwhile and
// then waits in its update cycle until the output register frees up.
// Reset empties all entries, clears pointer and counts and sets policy
// to fifo with 8 ways.
module assoc_cache_fifo_lru_hit_tracker #(
    parameter int MAX_WAYS   = 32,
    parameter int BLOCK_BITS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [6:0] block_number, [7] zero
    input  logic [acfl_pkg::IN_TD_W-1:0]      i_s_axis_tdata,
    // [0] start_run
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] hit, [32:1] hit_count, [64:33] reference_count, [71:65] zero
    output logic [acfl_pkg::OUT_TD_W-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [acfl_pkg::CFG_A_W-1:0]      i_cfg_addr,
    input  logic [acfl_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int PTR_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WW    = acfl_pkg::WAYS_W;
    localparam int CW    = acfl_pkg::COUNT_W;
    localparam logic [WW-1:0] MAX_WAYS_V = WW'(MAX_WAYS);

    logic                  r_policy;
    logic [acfl_pkg::CFG_W-1:0] r_ways_cfg;
    logic                  r_busy;
    logic [BLOCK_BITS-1:0] r_tag;
    logic [PTR_W-1:0]      r_ptr;
    logic [PTR_W-1:0]      n_ptr;
    logic [CW-1:0]         r_hits;
    logic [CW-1:0]         r_refs;
    logic [CW-1:0]         n_hits;
    logic [CW-1:0]         n_refs;
    logic                  r_out_valid;
    logic [acfl_pkg::OUT_TD_W-1:0] r_out_data;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_upd;
    logic                  w_hit;
    logic [WW-1:0]         w_ways;
    logic [WW-1:0]         w_ways_raw;
    logic [PTR_W-1:0]      w_ptr_eff;
    logic [WW-1:0]         w_ptr_inc;
    acfl_pkg::t_cell_ctrl  w_ctrl;

    logic [BLOCK_BITS-1:0] w_tag   [MAX_WAYS+1];
    logic                  w_valid [MAX_WAYS+1];
    logic                  w_below [MAX_WAYS+1];

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start  = w_accept && i_s_axis_tuser;
    assign w_upd    = r_busy && (!r_out_valid || i_m_axis_tready);
    assign w_hit    = w_below[MAX_WAYS];

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ways in use, held to 1..MAX_WAYS
    assign w_ways_raw = WW'(r_ways_cfg);
    always_comb begin
        if (w_ways_raw == '0) begin
            w_ways = WW'(1);
        end else if (w_ways_raw > MAX_WAYS_V) begin
            w_ways = MAX_WAYS_V;
        end else begin
            w_ways = w_ways_raw;
        end
    end

    assign w_ptr_eff = (WW'(r_ptr) >= w_ways) ? '0 : r_ptr;
    assign w_ptr_inc = WW'(w_ptr_eff) + WW'(1);
    assign n_ptr     = (w_ptr_inc >= w_ways) ? '0 : PTR_W'(w_ptr_inc);

    assign w_ctrl.clear    = w_start;
    assign w_ctrl.lru_upd  = w_upd && (r_policy == acfl_pkg::POLICY_LRU);
    assign w_ctrl.fifo_upd = w_upd && (r_policy == acfl_pkg::POLICY_FIFO) && !w_hit;

    assign n_hits = (w_hit && (r_hits != acfl_pkg::COUNT_MAX)) ? r_hits + CW'(1) : r_hits;
    assign n_refs = (r_refs != acfl_pkg::COUNT_MAX) ? r_refs + CW'(1) : r_refs;

    // front of the recency stack takes the new tag
    assign w_tag[0]   = r_tag;
    assign w_valid[0] = 1'b1;
    assign w_below[0] = 1'b0;

    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_cell
        acfl_cell #(
            .IDX   (g),
            .TAG_W (BLOCK_BITS),
            .PTR_W (PTR_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_ways       (w_ways),
            .i_ptr        (w_ptr_eff),
            .i_tag        (r_tag),
            .i_prev_tag   (w_tag[g]),
            .i_prev_valid (w_valid[g]),
            .i_below      (w_below[g]),
            .o_tag        (w_tag[g+1]),
            .o_valid      (w_valid[g+1]),
            .o_below      (w_below[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= acfl_pkg::POLICY_FIFO;
            r_ways_cfg <= acfl_pkg::WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                acfl_pkg::REG_POLICY: r_policy   <= i_cfg_wdata[0];
                acfl_pkg::REG_WAYS:   r_ways_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_hits      <= '0;
            r_refs      <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_upd) begin
                r_busy <= 1'b0;
            end

            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_start) begin
                r_ptr  <= '0;
                r_hits <= '0;
                r_refs <= '0;
            end else if (w_upd) begin
                r_hits <= n_hits;
                r_refs <= n_refs;
                if (w_ctrl.fifo_upd) begin
                    r_ptr <= n_ptr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag <= BLOCK_BITS'(i_s_axis_tdata[acfl_pkg::BLOCK_W-1:0]);
        end
        if (w_upd) begin
            r_out_data <= {7'd0, n_refs, n_hits, w_hit};
        end
    end

endmodule

@@ design/acfl_cell.sv @@
// one cache entry: tag, valid bit, match and hand-over to the next entry
module acfl_cell #(
    parameter int IDX     = 0,
    parameter int TAG_W   = 7,
    parameter int PTR_W   = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  acfl_pkg::t_cell_ctrl            i_ctrl,
    input  logic [acfl_pkg::WAYS_W-1:0]     i_ways,
    input  logic [PTR_W-1:0]                i_ptr,
    input  logic [TAG_W-1:0]                i_tag,
    input  logic [TAG_W-1:0]                i_prev_tag,
    input  logic                            i_prev_valid,
    input  logic                            i_below,
    output logic [TAG_W-1:0]                o_tag,
    output logic                            o_valid,
    output logic                            o_below
);

    localparam logic [acfl_pkg::WAYS_W-1:0] IDX_W = acfl_pkg::WAYS_W'(IDX);
    localparam logic [PTR_W-1:0]            IDX_P = PTR_W'(IDX);

    logic [TAG_W-1:0] r_tag;
    logic             r_valid;
    logic             w_in_use;
    logic             w_match;

    assign w_in_use = IDX_W < i_ways;
    assign w_match  = w_in_use && r_valid && (r_tag == i_tag);
    assign o_below  = i_below | w_match;
    assign o_tag    = r_tag;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.lru_upd && w_in_use && !i_below) begin
            r_valid <= i_prev_valid;
        end else if (i_ctrl.fifo_upd && (i_ptr == IDX_P)) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.lru_upd && w_in_use && !i_below) begin
            r_tag <= i_prev_tag;
        end else if (i_ctrl.fifo_upd && (i_ptr == IDX_P)) begin
            r_tag <= i_tag;
        end
    end

endmodule

@@ tb/tb_assoc_cache_fifo_lru_hit_tracker.sv @@
// self-checking testbench for the fully associative cache hit tracker
module tb_assoc_cache_fifo_lru_hit_tracker;

    import acfl_pkg::*;

    localparam int MAX_WAYS   = 32;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    class cache_hit_predictor;
        typedef struct {
            logic               hit;
            logic [COUNT_W-1:0] hit_count;
            logic [COUNT_W-1:0] ref_count;
        } lookup_result_t;

        logic [BLOCK_W-1:0] tags [MAX_WAYS];
        bit                 valid [MAX_WAYS];
        int unsigned        insert_ptr;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] ref_total;
        logic               policy;
        logic [CFG_W-1:0]   ways_reg;
        lookup_result_t     pending_results[$];
        int unsigned        mismatches;
        int unsigned        references;
        int unsigned        beats_checked;
        int unsigned        hits_seen;
        int unsigned        restarts;
        int unsigned        lru_refs;

        function new();
            policy        = POLICY_FIFO;
            ways_reg      = WAYS_RESET;
            mismatches    = 0;
            references    = 0;
            beats_checked = 0;
            hits_seen     = 0;
            restarts      = 0;
            lru_refs      = 0;
            clear_run();
        endfunction

        function void clear_run();
            for (int i = 0; i < MAX_WAYS; i++) begin
                tags[i]  = '0;
                valid[i] = 1'b0;
            end
            insert_ptr = 0;
            hit_total  = '0;
            ref_total  = '0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_W-1:0] data);
            if (addr == REG_POLICY)
                policy = data[0];
            else if (addr == REG_WAYS)
                ways_reg = data;
        endfunction

        function int unsigned active_ways();
            if (ways_reg == 0)
                return 1;
            if (ways_reg > MAX_WAYS)
                return MAX_WAYS;
            return ways_reg;
        endfunction

        function void note_reference(logic [BLOCK_W-1:0] blk, logic start);
            int unsigned    w;
            int unsigned    found_at;
            int unsigned    top;
            int unsigned    p;
            bit             found;
            lookup_result_t r;
            if (start) begin
                clear_run();
                restarts++;
            end
            w        = active_ways();
            found    = 1'b0;
            found_at = 0;
            for (int i = 0; i < w; i++) begin
                if (!found && valid[i] && tags[i] == blk) begin
                    found    = 1'b1;
                    found_at = i;
                end
            end
            if (found && hit_total != COUNT_MAX)
                hit_total++;
            if (ref_total != COUNT_MAX)
                ref_total++;
            if (policy == POLICY_FIFO) begin
                if (!found) begin
                    p = insert_ptr;
                    if (p >= w)
                        p = 0;
                    tags[p]  = blk;
                    valid[p] = 1'b1;
                    p++;
                    if (p >= w)
                        p = 0;
                    insert_ptr = p;
                end
            end else begin
                lru_refs++;
                top = found ? found_at : w - 1;
                for (int i = top; i > 0; i--) begin
                    tags[i]  = tags[i-1];
                    valid[i] = valid[i-1];
                end
                tags[0]  = blk;
                valid[0] = 1'b1;
            end
            if (found)
                hits_seen++;
            r.hit       = found;
            r.hit_count = hit_total;
            r.ref_count = ref_total;
            pending_results.push_back(r);
            references++;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [OUT_TD_W-1:0] beat);
            lookup_result_t     want;
            logic               got_hit;
            logic [COUNT_W-1:0] got_hc;
            logic [COUNT_W-1:0] got_rc;
            got_hit = beat[0];
            got_hc  = beat[32:1];
            got_rc  = beat[64:33];
            beats_checked++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected beat hit=%0d hits=%0d refs=%0d",
                                     got_hit, got_hc, got_rc));
                return;
            end
            want = pending_results.pop_front();
            if (got_hit !== want.hit || got_hc !== want.hit_count ||
                got_rc !== want.ref_count)
                flag_error($sformatf(
                    "beat %0d expected hit=%0d hits=%0d refs=%0d got hit=%0d hits=%0d refs=%0d",
                    beats_checked, want.hit, want.hit_count, want.ref_count,
                    got_hit, got_hc, got_rc));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_TD_W-1:0]  i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0] o_m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;

    cache_hit_predictor  model = new();
    int unsigned         burst_left = 0;
    int unsigned         idle_cycles = 0;
    int unsigned         settings_used = 0;
    bit                  long_hold_done = 1'b0;

    assoc_cache_fifo_lru_hit_tracker #(
        .MAX_WAYS   (MAX_WAYS),
        .BLOCK_BITS (BLOCK_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // beat monitor and idle watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            model.check_result(o_m_axis_tdata);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            model.note_reference(i_s_axis_tdata[BLOCK_W-1:0], i_s_axis_tuser);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic hold_ready(input logic level, input int unsigned n);
        repeat (n) @(negedge i_clk) i_m_axis_tready <= level;
    endtask

    // receiver stall pattern, with one long hold-off to back up the input
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!long_hold_done && model.references >= 350) begin
                long_hold_done = 1'b1;
                hold_ready(1'b0, LONG_HOLD);
            end else if ($urandom_range(0, 3) == 0) begin
                hold_ready(1'b1, $urandom_range(20, 60));
            end else begin
                hold_ready(1'b1, $urandom_range(1, 8));
                hold_ready(1'b0, $urandom_range(1, 5));
            end
        end
    end

    task automatic send_ref(input logic [BLOCK_W-1:0] blk, input logic start);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6))
                @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, blk};
        i_s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        model.write_reg(addr, data);
    endtask

    task automatic apply_setting(input logic pol, input logic [CFG_W-1:0] ways);
        drain();
        write_reg(REG_POLICY, CFG_W'(pol));
        write_reg(REG_WAYS, ways);
        settings_used++;
    endtask

    // references drawn mostly from a working set a little larger than the cache
    task automatic run_phase(input int unsigned n_refs);
        int unsigned        span;
        int unsigned        base;
        logic [BLOCK_W-1:0] blk;
        logic               start;
        span = model.active_ways() + $urandom_range(0, model.active_ways() / 2 + 3);
        base = $urandom_range(0, 127);
        for (int k = 0; k < n_refs; k++) begin
            if ($urandom_range(0, 9) == 0)
                blk = BLOCK_W'($urandom_range(0, 127));
            else
                blk = BLOCK_W'(base + $urandom_range(0, span));
            start = (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 59) == 0);
            send_ref(blk, start);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] fixed_ways [8];
        logic             fixed_pol  [8];
        fixed_ways = '{6'd1, 6'd1, 6'd32, 6'd32, 6'd63, 6'd0, 6'd8, 6'd17};
        fixed_pol  = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                       POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // fifo with reset ways: empty entries, extremes, fill and wrap
        send_ref(7'd0, 1'b1);
        send_ref(7'd0, 1'b0);
        send_ref(7'd127, 1'b0);
        send_ref(7'd127, 1'b0);
        for (int k = 1; k <= 7; k++)
            send_ref(BLOCK_W'(k), 1'b0);
        send_ref(7'd0, 1'b0);
        // fewer ways: stale insert pointer, entries beyond left alone
        drain();
        write_reg(REG_WAYS, 6'd3);
        send_ref(7'd9, 1'b0);
        send_ref(7'd9, 1'b0);
        send_ref(7'd5, 1'b0);
        // policy change mid run, ways of zero acts as one
        drain();
        write_reg(REG_POLICY, CFG_W'(POLICY_LRU));
        write_reg(REG_WAYS, 6'd0);
        send_ref(7'd9, 1'b0);
        send_ref(7'd4, 1'b0);
        // ways above the maximum; old entries return, duplicates possible
        drain();
        write_reg(REG_WAYS, 6'd63);
        send_ref(7'd5, 1'b0);
        send_ref(7'd9, 1'b0);
        send_ref(7'd127, 1'b0);
        send_ref(7'd4, 1'b0);

        for (int ph = 0; ph < 20; ph++) begin
            if (ph < 8)
                apply_setting(fixed_pol[ph], fixed_ways[ph]);
            else
                apply_setting(logic'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 63)));
            run_phase($urandom_range(40, 85));
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d references over %0d register settings, %0d hits, %0d restarts",
                 model.references, settings_used, model.hits_seen, model.restarts);
        $display("summary: %0d references under lru, one output hold-off of %0d cycles",
                 model.lru_refs, LONG_HOLD);
        if (model.mismatches == 0 && model.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", model.mismatches,
                     model.pending_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
